// ===== rtl/tspsa_pkg.sv =====
// Package for the transport-stream packet sync aligner.
// Holds packet and window geometry, the sync mark, pointer helpers and the result type.
// No dependencies.
package tspsa_pkg;

  // Packet geometry and lock depth.
  localparam int SYNC_RUN     = 4;
  localparam int PACKET_BYTES = 188;
  localparam int WINDOW_BYTES = SYNC_RUN * PACKET_BYTES;

  localparam logic [7:0] SYNC_MARK = 8'h47;

  // Widths of pointers, counters and the per-byte sync run length.
  localparam int WIN_AW = $clog2(WINDOW_BYTES);
  localparam int PKT_AW = $clog2(PACKET_BYTES);
  localparam int RUN_W  = $clog2(SYNC_RUN + 1);

  // One result item.
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       last;
  } tspsa_res_t;

  // Advance a pointer around the window ring.
  function automatic logic [WIN_AW-1:0] win_inc(input logic [WIN_AW-1:0] p);
    return (p == WIN_AW'(WINDOW_BYTES - 1)) ? '0 : p + WIN_AW'(1);
  endfunction

  // Advance a pointer around the one-packet run ring.
  function automatic logic [PKT_AW-1:0] pkt_inc(input logic [PKT_AW-1:0] p);
    return (p == PKT_AW'(PACKET_BYTES - 1)) ? '0 : p + PKT_AW'(1);
  endfunction

endpackage

// ===== rtl/ts_packet_sync_aligner.sv =====
// Transport-stream packet sync aligner: finds and tracks 0x47 packet alignment.
// Depends on tspsa_pkg for geometry, pointer helpers and the result type.
//
// Usage: raw stream bytes enter on the s_axis channel, one byte per item.
// Aligned packet bytes leave on the m_axis channel; tuser marks the sync
// byte of each packet and tlast marks its final byte.
// The block keeps a look-ahead window of SYNC_RUN packets. The first
// WINDOW_BYTES-1 items after reset only fill the window and give no result.
// From then on every item releases the oldest byte of the window, which is
// either sent or dropped (a one-byte slip while hunting for alignment).
// Hunting locks only when 0x47 appears at every packet spacing across the
// whole window; while locked, a packet start without 0x47 drops the lock.
// Throughput: one item per cycle while s_axis_tready is high. The window
// bytes and the per-position sync run lengths sit in two ring memories;
// each is read one position ahead of the write pointer, so every accepted
// item finds its data ready. A released result is registered in the
// output register, or in the skid stage while m_axis stalls.
// Reset clears pointers, fill count, lock and packet offset at once; the
// memories need no clearing pass. When the receiver stalls, a skid stage
// holds one extra result and s_axis_tready falls only once it is in use.
module ts_packet_sync_aligner (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tuser,   // [0] packet_start
  output logic       m_axis_tlast    // packet_end
);
  import tspsa_pkg::*;

  // Ring memories: window bytes and sync run length per stream position.
  logic [7:0]       byte_mem [WINDOW_BYTES];
  logic [RUN_W-1:0] run_mem  [PACKET_BYTES];

  logic [WIN_AW-1:0] wr_ptr;
  logic [PKT_AW-1:0] run_ptr;
  logic [WIN_AW-1:0] fill_count;
  logic [WIN_AW-1:0] byte_raddr;
  logic [PKT_AW-1:0] run_raddr;
  logic [7:0]        head_q;
  logic [RUN_W-1:0]  run_q;
  logic [RUN_W-1:0]  run_prev;
  logic [RUN_W-1:0]  run_base;
  logic [RUN_W-1:0]  run_new;

  logic              locked;
  logic              locked_next;
  logic [7:0]        offset;
  logic [7:0]        offset_next;

  logic              accept;
  logic              full;
  logic              sync_ok;
  logic              emit;
  tspsa_res_t        res;
  tspsa_res_t        out_reg;
  tspsa_res_t        skid_reg;
  logic              skid_valid;
  logic              out_free;

  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (fill_count == WIN_AW'(WINDOW_BYTES - 1));

  // Read one slot ahead of the pointer as it stands after this edge.
  assign byte_raddr = win_inc(accept ? win_inc(wr_ptr) : wr_ptr);
  assign run_raddr  = pkt_inc(accept ? pkt_inc(run_ptr) : run_ptr);

  // Run length of 0x47 bytes at packet spacing ending at this byte.
  // Positions before the first packet have no predecessor.
  assign run_base = (fill_count < WIN_AW'(PACKET_BYTES)) ? '0 : run_prev;
  assign run_new  = (s_axis_tdata != SYNC_MARK) ? '0 :
                    (run_base >= RUN_W'(SYNC_RUN)) ? RUN_W'(SYNC_RUN) :
                    run_base + RUN_W'(1);

  // The run ending one packet below the newest byte covers the whole
  // window from the oldest byte on.
  assign sync_ok = (run_q >= RUN_W'(SYNC_RUN));

  // Memory writes and registered reads.
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_mem[wr_ptr] <= s_axis_tdata;
      run_mem[run_ptr] <= run_new;
    end
    head_q <= byte_mem[byte_raddr];
    run_q  <= run_mem[run_raddr];
  end

  // Lock decision for the oldest byte in the window.
  always_comb begin
    emit        = 1'b0;
    res.start   = 1'b0;
    locked_next = locked;
    if (full) begin
      if (locked && offset != 8'd0) begin
        emit = 1'b1;
      end else if (locked && head_q == SYNC_MARK) begin
        emit      = 1'b1;
        res.start = 1'b1;
      end else begin
        locked_next = sync_ok;
        emit        = sync_ok;
        res.start   = sync_ok;
      end
    end
    res.data    = head_q;
    res.last    = emit && (offset == 8'(PACKET_BYTES - 1));
    offset_next = !emit ? offset : (res.last ? 8'd0 : offset + 8'd1);
  end

  // Pointers, fill count and lock state.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      run_ptr    <= '0;
      fill_count <= '0;
      locked     <= 1'b0;
      offset     <= 8'd0;
    end else if (accept) begin
      wr_ptr  <= win_inc(wr_ptr);
      run_ptr <= pkt_inc(run_ptr);
      if (!full) begin
        fill_count <= fill_count + WIN_AW'(1);
      end
      locked <= locked_next;
      offset <= offset_next;
    end
  end

  // The run just read is the predecessor of the next item.
  always_ff @(posedge clk) begin
    if (accept) begin
      run_prev <= run_q;
    end
  end

  // Output register with one skid stage behind it.
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        m_axis_tvalid <= 1'b1;
        skid_valid    <= 1'b0;
      end else begin
        m_axis_tvalid <= accept && emit;
      end
    end else if (accept && emit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_reg <= skid_valid ? skid_reg : res;
    end else if (accept && emit) begin
      skid_reg <= res;
    end
  end

  assign m_axis_tdata = out_reg.data;
  assign m_axis_tuser = out_reg.start;
  assign m_axis_tlast = out_reg.last;

  // A result only waits in the skid stage behind a stalled output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_axis_tvalid)
    else $error("skid stage holds an item while the output is empty");

  // A packet start is always the sync mark.
  a_start_is_sync: assert property (@(posedge clk) disable iff (rst)
    (accept && emit && res.start) |-> (res.data == SYNC_MARK))
    else $error("packet start sent without sync mark");

  // Mid-packet offsets exist only under lock.
  a_offset_locked: assert property (@(posedge clk) disable iff (rst)
    (offset != 8'd0) |-> locked)
    else $error("packet offset advanced while hunting");

  // The last byte of a packet returns the offset to the packet start.
  a_end_wraps: assert property (@(posedge clk) disable iff (rst)
    (accept && emit && res.last) |=> (offset == 8'd0))
    else $error("offset did not wrap after packet end");

  // Nothing is released while the window is still filling.
  a_no_emit_filling: assert property (@(posedge clk) disable iff (rst)
    !full |-> !emit)
    else $error("item released before window filled");

endmodule
